[sv/tce_pkg.sv]
// Shared types and constants for the tiny CPU instruction execute core.
// Used by tce_regfile, tce_dmem and tiny_cpu_instruction_execute_core.
package tce_pkg;

  // Default sizes of the machine
  localparam int MemWordsDef     = 128;
  localparam int ProgramLinesDef = 512;
  localparam int NumRegsDef      = 6;

  // Value returned by a data read outside the memory
  localparam logic [31:0] MemOorValue = 32'hFFFF_FFFF;

  // Command codes; anything above INP is an unknown command
  typedef enum logic [3:0] {
    CMD_HLT = 4'd0,
    CMD_MOV = 4'd1,
    CMD_ADD = 4'd2,
    CMD_SUB = 4'd3,
    CMD_JPN = 4'd4,
    CMD_JMP = 4'd5,
    CMD_PRN = 4'd6,
    CMD_INP = 4'd7
  } cmd_e;

  // Operand kinds; the unused fourth code reads as an immediate
  typedef enum logic [1:0] {
    KIND_REG = 2'd0,
    KIND_MEM = 2'd1,
    KIND_IMM = 2'd2
  } kind_e;

  // Error codes reported with each result
  typedef enum logic [1:0] {
    ERR_NONE        = 2'd0,
    ERR_CONST_DST   = 2'd1,
    ERR_DST_NOT_REG = 2'd2,
    ERR_UNKNOWN_CMD = 2'd3
  } err_e;

  // Write request into the register file or the data memory
  typedef struct packed {
    logic        en;
    logic [31:0] addr;
    logic [31:0] data;
  } wr_req_t;

endpackage

[sv/tce_regfile.sv]
// Register file of the tiny CPU: NUM_REGS words, numbered from one,
// two registered read ports with write forwarding. Depends on tce_pkg.
module tce_regfile #(
  parameter int NUM_REGS = tce_pkg::NumRegsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [31:0]      rd_a_num_i,
  input  logic [31:0]      rd_b_num_i,
  input  tce_pkg::wr_req_t wr_i,
  output logic [31:0]      rd_a_data_o,
  output logic [31:0]      rd_b_data_o
);
  import tce_pkg::*;

  localparam int IdxW = $clog2(NUM_REGS);

  logic [31:0]     rf_q [NUM_REGS];
  logic [31:0]     rd_a_q, rd_b_q;
  logic [31:0]     rd_a_d, rd_b_d;
  logic            wr_ok;
  logic [IdxW-1:0] wr_idx;
  logic            a_ok, b_ok;
  logic [IdxW-1:0] a_idx, b_idx;
  logic [31:0]     a_m1, b_m1, w_m1;

  // Decode register numbers; an out-of-range number points at entry zero
  always_comb begin
    a_m1   = rd_a_num_i - 32'd1;
    b_m1   = rd_b_num_i - 32'd1;
    w_m1   = wr_i.addr - 32'd1;
    a_ok   = (rd_a_num_i >= 32'd1) && (rd_a_num_i <= 32'(NUM_REGS));
    b_ok   = (rd_b_num_i >= 32'd1) && (rd_b_num_i <= 32'(NUM_REGS));
    wr_ok  = wr_i.en && (wr_i.addr >= 32'd1) && (wr_i.addr <= 32'(NUM_REGS));
    a_idx  = a_ok ? a_m1[IdxW-1:0] : '0;
    b_idx  = b_ok ? b_m1[IdxW-1:0] : '0;
    wr_idx = wr_ok ? w_m1[IdxW-1:0] : '0;
  end

  // Select read data: zero when out of range, forwarded when written now
  always_comb begin
    if (!a_ok) begin
      rd_a_d = '0;
    end else if (wr_ok && (wr_idx == a_idx)) begin
      rd_a_d = wr_i.data;
    end else begin
      rd_a_d = rf_q[a_idx];
    end
    if (!b_ok) begin
      rd_b_d = '0;
    end else if (wr_ok && (wr_idx == b_idx)) begin
      rd_b_d = wr_i.data;
    end else begin
      rd_b_d = rf_q[b_idx];
    end
  end

  // Write storage; reset clears every register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_q <= '{default: '0};
    end else if (wr_ok) begin
      rf_q[wr_idx] <= wr_i.data;
    end
  end

  // Capture read data on the accepted beat, hold otherwise
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_a_q <= rd_a_d;
      rd_b_q <= rd_b_d;
    end
  end

  assign rd_a_data_o = rd_a_q;
  assign rd_b_data_o = rd_b_q;

endmodule

[sv/tce_dmem.sv]
// Data memory of the tiny CPU: MEM_WORDS words with per-word valid bits,
// one registered read port with write forwarding. Depends on tce_pkg.
module tce_dmem #(
  parameter int MEM_WORDS = tce_pkg::MemWordsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [31:0]      rd_addr_i,
  input  tce_pkg::wr_req_t wr_i,
  output logic [31:0]      rd_data_o
);
  import tce_pkg::*;

  localparam int AddrW = $clog2(MEM_WORDS);

  logic [31:0]          mem [MEM_WORDS];
  logic [MEM_WORDS-1:0] vld_q;
  logic [31:0]          mem_rd_q;
  logic                 hit_q, fwd_q, oor_q;
  logic [31:0]          fwd_data_q;
  logic                 rd_in, wr_ok;
  logic [AddrW-1:0]     rd_idx, wr_idx;

  // Range checks; out-of-range addresses point at word zero
  always_comb begin
    rd_in  = rd_addr_i < 32'(MEM_WORDS);
    wr_ok  = wr_i.en && (wr_i.addr < 32'(MEM_WORDS));
    rd_idx = rd_in ? rd_addr_i[AddrW-1:0] : '0;
    wr_idx = wr_ok ? wr_i.addr[AddrW-1:0] : '0;
  end

  // Write the array, read it on the accepted beat
  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem[wr_idx] <= wr_i.data;
    end
    if (rd_en_i) begin
      mem_rd_q <= mem[rd_idx];
    end
  end

  // Mark written words, remember how to resolve the read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      hit_q <= 1'b0;
      fwd_q <= 1'b0;
      oor_q <= 1'b0;
    end else begin
      if (wr_ok) begin
        vld_q[wr_idx] <= 1'b1;
      end
      if (rd_en_i) begin
        hit_q <= vld_q[rd_idx];
        fwd_q <= wr_ok && (wr_idx == rd_idx) && rd_in;
        oor_q <= !rd_in;
      end
    end
  end

  // Hold the forwarded word
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      fwd_data_q <= wr_i.data;
    end
  end

  // Out-of-range reads return MemOorValue; never-written words read as zero
  always_comb begin
    if (oor_q) begin
      rd_data_o = MemOorValue;
    end else if (fwd_q) begin
      rd_data_o = fwd_data_q;
    end else if (hit_q) begin
      rd_data_o = mem_rd_q;
    end else begin
      rd_data_o = '0;
    end
  end

endmodule

[sv/tiny_cpu_instruction_execute_core.sv]
// Tiny CPU instruction execute core: one pre-decoded instruction per beat.
// Stages: operand read, then execute. Throughput: one instruction per cycle
// unless the result is stalled; register file and data memory are read as
// the beat is taken and written back in the execute cycle, forwarded.
// Reset clears registers, line counter, stop flag and memory valid bits at
// once; no clearing pass, inputs are taken from the first cycle after reset.
module tiny_cpu_instruction_execute_core #(
  parameter int MEM_WORDS     = tce_pkg::MemWordsDef,
  parameter int PROGRAM_LINES = tce_pkg::ProgramLinesDef,
  parameter int NUM_REGS      = tce_pkg::NumRegsDef,
  localparam int LineW        = $clog2(PROGRAM_LINES + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [3:0]          cmd_i,
  input  logic [1:0]          first_kind_i,
  input  logic signed [31:0]  first_value_i,
  input  logic [1:0]          second_kind_i,
  input  logic signed [31:0]  second_value_i,
  input  logic [LineW-1:0]    jump_line_i,
  input  logic [7:0]          input_char_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [LineW-1:0]    next_line_o,
  output logic                halted_o,
  output logic                print_valid_o,
  output logic signed [31:0]  print_value_o,
  output logic [1:0]          error_code_o
);
  import tce_pkg::*;

  localparam logic [LineW-1:0] LastLine = LineW'(PROGRAM_LINES);

  // Handshake and pipeline control
  logic advance, in_accept, fire;
  logic s1_valid_q, out_valid_q;

  // Execute-stage instruction
  logic [3:0]       cmd_q;
  logic [1:0]       k1_q, k2_q;
  logic [31:0]      v1_q, v2_q;
  logic [LineW-1:0] jl_q;
  logic [7:0]       ch_q;

  // Architectural state
  logic [LineW-1:0] line_q;
  logic             stopped_q;

  // Read data and write requests
  logic [31:0] rf_a, rf_b, dm_rd, dm_rd_addr;
  wr_req_t     rf_wr, dm_wr;

  // Execute results
  logic [LineW-1:0] next_d, target;
  logic             run, stop_d, pvalid_d;
  logic [31:0]      pval_d, op1, op2;
  err_e             err_d;

  // Result register
  logic [LineW-1:0] next_line_q;
  logic             halted_q, print_valid_q;
  logic [31:0]      print_value_q;
  logic [1:0]       error_code_q;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign fire       = s1_valid_q && advance;

  // Memory operand comes from the first field only for JPN and PRN
  always_comb begin
    if (cmd_i inside {CMD_JPN, CMD_PRN}) begin
      dm_rd_addr = first_value_i;
    end else begin
      dm_rd_addr = second_value_i;
    end
  end

  tce_regfile #(
    .NUM_REGS(NUM_REGS)
  ) u_regfile (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_accept),
    .rd_a_num_i (first_value_i),
    .rd_b_num_i (second_value_i),
    .wr_i       (rf_wr),
    .rd_a_data_o(rf_a),
    .rd_b_data_o(rf_b)
  );

  tce_dmem #(
    .MEM_WORDS(MEM_WORDS)
  ) u_dmem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (in_accept),
    .rd_addr_i(dm_rd_addr),
    .wr_i     (dm_wr),
    .rd_data_o(dm_rd)
  );

  // Capture the instruction beat
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q <= cmd_i;
      k1_q  <= first_kind_i;
      v1_q  <= first_value_i;
      k2_q  <= second_kind_i;
      v2_q  <= second_value_i;
      jl_q  <= jump_line_i;
      ch_q  <= input_char_i;
    end
  end

  // Resolve operands by kind
  always_comb begin
    case (k1_q)
      KIND_REG: op1 = rf_a;
      KIND_MEM: op1 = dm_rd;
      default:  op1 = v1_q;
    endcase
    case (k2_q)
      KIND_REG: op2 = rf_b;
      KIND_MEM: op2 = dm_rd;
      default:  op2 = v2_q;
    endcase
  end

  // Jump target: line zero maps to index zero, saturate past the end
  always_comb begin
    target = (jl_q == '0) ? '0 : jl_q - LineW'(1);
    if (target > LastLine) begin
      target = LastLine;
    end
  end

  // Execute the instruction
  always_comb begin
    run      = !stopped_q && (line_q != LastLine);
    next_d   = line_q + LineW'(1);
    stop_d   = 1'b0;
    pvalid_d = 1'b0;
    pval_d   = '0;
    err_d    = ERR_NONE;
    rf_wr    = '{en: 1'b0, addr: v1_q, data: op2};
    dm_wr    = '{en: 1'b0, addr: v1_q, data: op2};
    case (cmd_q)
      CMD_HLT: stop_d = 1'b1;
      CMD_MOV: begin
        if (k1_q == KIND_REG) begin
          rf_wr.en = 1'b1;
        end else if (k1_q == KIND_MEM) begin
          dm_wr.en = 1'b1;
        end else begin
          err_d  = ERR_CONST_DST;
          stop_d = 1'b1;
        end
      end
      CMD_ADD, CMD_SUB: begin
        if (k1_q != KIND_REG) begin
          err_d  = ERR_DST_NOT_REG;
          stop_d = 1'b1;
        end else begin
          rf_wr.en   = 1'b1;
          rf_wr.data = (cmd_q == CMD_ADD) ? rf_a + op2 : rf_a - op2;
        end
      end
      CMD_JPN: begin
        if ((op1 == '0) || op1[31]) begin
          next_d = target;
        end
      end
      CMD_JMP: next_d = target;
      CMD_PRN: begin
        pvalid_d = 1'b1;
        pval_d   = op1;
      end
      CMD_INP: begin
        if (k1_q != KIND_REG) begin
          err_d  = ERR_DST_NOT_REG;
          stop_d = 1'b1;
        end else begin
          rf_wr.en   = 1'b1;
          rf_wr.data = {24'd0, ch_q};
        end
      end
      default: err_d = ERR_UNKNOWN_CMD;
    endcase
    if (stop_d) begin
      next_d = line_q;
    end
    // Drop everything when stopped or past the end of the program
    if (!run) begin
      next_d   = line_q;
      stop_d   = 1'b0;
      pvalid_d = 1'b0;
      pval_d   = '0;
      err_d    = ERR_NONE;
      rf_wr.en = 1'b0;
      dm_wr.en = 1'b0;
    end
    rf_wr.en = rf_wr.en && fire;
    dm_wr.en = dm_wr.en && fire;
  end

  // Advance control and machine state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      line_q      <= '0;
      stopped_q   <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
      if (fire) begin
        line_q    <= next_d;
        stopped_q <= stopped_q || stop_d;
      end
    end
  end

  // Load the result beat
  always_ff @(posedge clk_i) begin
    if (fire) begin
      next_line_q   <= next_d;
      halted_q      <= stopped_q || stop_d;
      print_valid_q <= pvalid_d;
      print_value_q <= pval_d;
      error_code_q  <= err_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign next_line_o   = next_line_q;
  assign halted_o      = halted_q;
  assign print_valid_o = print_valid_q;
  assign print_value_o = print_value_q;
  assign error_code_o  = error_code_q;

`ifndef ASSERT_OFF
  // A stopped machine stays stopped
  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |=> stopped_q)
    else $error("stop flag cleared");

  // A stopped machine keeps its line counter
  a_stop_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |=> $stable(line_q))
    else $error("line counter moved while stopped");

  // Input stalls only while the execute stage waits on a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without cause");

  // State writes only from a running, firing instruction
  a_write_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rf_wr.en || dm_wr.en) |-> (fire && run))
    else $error("state written outside execution");

  // Line counter never passes the end of the program
  a_line_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q <= LastLine)
    else $error("line counter out of range");
`endif

endmodule
